// File: rtl/core/nnsa_pkg.sv
package nnsa_pkg;

    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int BPP_W   = 3;
    localparam int NUM_W   = 24;
    localparam int OFF_W   = 26;
    localparam int Q_W     = 12;
    localparam int REM_W   = NUM_W + 1;
    localparam int ADDR_W  = 3;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;

    localparam logic [DIM_W-1:0] MAX_DIM             = 13'd4096;
    localparam logic [BPP_W-1:0] MAX_BYTES_PER_PIXEL = 3'd4;

    localparam logic [ADDR_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [ADDR_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [ADDR_W-1:0] REG_BPP        = 3'd4;

    // Partial remainders and quotients of the two dividers.
    typedef struct packed {
        logic [NUM_W-1:0]   rem_x;
        logic [NUM_W-1:0]   rem_y;
        logic [Q_W-1:0]     q_x;
        logic [Q_W-1:0]     q_y;
    } div_t;

    // Fields that ride alongside the dividers.
    typedef struct packed {
        logic               in_range;
        logic [COORD_W-1:0] dest_x;
        logic [NUM_W-1:0]   dst_row;
    } side_t;

    typedef struct packed {
        logic               in_range;
        logic [OFF_W-1:0]   dst_offset;
        logic [OFF_W-1:0]   src_offset;
        logic [COORD_W-1:0] src_y;
        logic [COORD_W-1:0] src_x;
    } res_t;

endpackage

// File: rtl/core/nearest_neighbor_scale_addr.sv
// Channel   Direction  Fields (tdata, lowest bit up)
// s_        in         dest_x[11:0], dest_y[23:12]
// m_        out        src_x[11:0], src_y[23:12], src_offset[49:24], dst_offset[75:50],
//                      in_range[76], zero fill [79:77]
// cfg_      in         write enable, register index, 13-bit write data
//
// One item per clock while the skid register is empty. A result passes through one register for
// the products, twelve divider stages that each settle one quotient bit, three offset registers
// and the output register. Reset clears all valid bits and loads the register defaults. A
// stalled output is held while a skid register takes one more item; input is refused only
// while that skid register is occupied.
module nearest_neighbor_scale_addr
    import nnsa_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // dest_x, dest_y
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // src_x, src_y, src_offset, dst_offset, in_range
    input  logic                   cfg_wr_en,
    input  logic [ADDR_W-1:0]      cfg_addr,
    input  logic [DIM_W-1:0]       cfg_wdata
);

    logic [DIM_W-1:0] src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic [BPP_W-1:0] bpp_reg;
    logic [DIM_W-1:0] dim_sat;
    logic [BPP_W-1:0] bpp_sat;

    assign dim_sat = (cfg_wdata > MAX_DIM) ? MAX_DIM : cfg_wdata;
    assign bpp_sat = (cfg_wdata[BPP_W-1:0] > MAX_BYTES_PER_PIXEL) ?
                     MAX_BYTES_PER_PIXEL : cfg_wdata[BPP_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= 13'd640;
            src_height_reg <= 13'd480;
            dst_width_reg  <= 13'd640;
            dst_height_reg <= 13'd480;
            bpp_reg        <= 3'd3;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SRC_WIDTH:  src_width_reg  <= dim_sat;
                REG_SRC_HEIGHT: src_height_reg <= dim_sat;
                REG_DST_WIDTH:  dst_width_reg  <= dim_sat;
                REG_DST_HEIGHT: dst_height_reg <= dim_sat;
                REG_BPP:        bpp_reg        <= bpp_sat;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together; it stops only while the skid register is full.
    logic skid_v_reg;
    logic adv;
    assign adv      = !skid_v_reg;
    assign s_tready = adv;

    logic in_xfer;
    assign in_xfer = s_tvalid && adv;

    // Stage 0: range check and the numerators.
    logic [COORD_W-1:0] in_x, in_y;
    logic [REM_W-1:0]   num_x_full, num_y_full, row_full;
    div_t               div0_next;
    side_t              side0_next;

    assign in_x = s_tdata[COORD_W-1:0];
    assign in_y = s_tdata[2*COORD_W-1:COORD_W];

    always_comb begin
        num_x_full           = REM_W'(in_x) * REM_W'(src_width_reg);
        num_y_full           = REM_W'(in_y) * REM_W'(src_height_reg);
        row_full             = REM_W'(in_y) * REM_W'(dst_width_reg);
        div0_next.rem_x      = num_x_full[NUM_W-1:0];
        div0_next.rem_y      = num_y_full[NUM_W-1:0];
        div0_next.q_x        = '0;
        div0_next.q_y        = '0;
        side0_next.in_range  = ({1'b0, in_x} < dst_width_reg) &&
                               ({1'b0, in_y} < dst_height_reg);
        side0_next.dest_x    = in_x;
        side0_next.dst_row   = row_full[NUM_W-1:0];
    end

    // Stages 1 to Q_W: restoring division, most significant quotient bit first.
    div_t  div_reg  [0:Q_W];
    side_t side_reg [0:Q_W];
    logic  v_reg    [0:Q_W];
    div_t  div_next [1:Q_W];

    always_comb begin
        logic [REM_W-1:0] dsh_x, dsh_y, dif_x, dif_y;
        for (int k = 1; k <= Q_W; k++) begin
            dsh_x       = REM_W'(dst_width_reg) << (Q_W - k);
            dsh_y       = REM_W'(dst_height_reg) << (Q_W - k);
            dif_x       = {1'b0, div_reg[k-1].rem_x} - dsh_x;
            dif_y       = {1'b0, div_reg[k-1].rem_y} - dsh_y;
            div_next[k] = div_reg[k-1];
            if (!dif_x[NUM_W]) begin
                div_next[k].rem_x        = dif_x[NUM_W-1:0];
                div_next[k].q_x[Q_W - k] = 1'b1;
            end
            if (!dif_y[NUM_W]) begin
                div_next[k].rem_y        = dif_y[NUM_W-1:0];
                div_next[k].q_y[Q_W - k] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_reg[0]  <= div0_next;
            side_reg[0] <= side0_next;
            for (int k = 1; k <= Q_W; k++) begin
                div_reg[k]  <= div_next[k];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= Q_W; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= in_xfer;
            for (int k = 1; k <= Q_W; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Offset stages: source row product, linear indexes, byte offsets.
    logic [COORD_W-1:0] m1_sx_reg, m1_sy_reg, m2_sx_reg, m2_sy_reg;
    logic [NUM_W-1:0]   m1_prod_reg, m1_dlin_reg, m2_slin_reg, m2_dlin_reg;
    logic               m1_inr_reg, m2_inr_reg;
    logic               m1_v_reg, m2_v_reg, m3_v_reg;
    res_t               m3_reg, m3_next;
    logic [REM_W-1:0]   sprod_full;
    logic [NUM_W-1:0]   dlin_next, slin_next;
    logic [OFF_W:0]     soff_full, doff_full;

    always_comb begin
        sprod_full = REM_W'(div_reg[Q_W].q_y) * REM_W'(src_width_reg);
        dlin_next  = side_reg[Q_W].dst_row + NUM_W'(side_reg[Q_W].dest_x);
        slin_next  = m1_prod_reg + NUM_W'(m1_sx_reg);
        soff_full  = (OFF_W+1)'(m2_slin_reg) * (OFF_W+1)'(bpp_reg);
        doff_full  = (OFF_W+1)'(m2_dlin_reg) * (OFF_W+1)'(bpp_reg);
        m3_next    = '0;
        if (m2_inr_reg) begin
            m3_next.in_range   = 1'b1;
            m3_next.src_x      = m2_sx_reg;
            m3_next.src_y      = m2_sy_reg;
            m3_next.src_offset = soff_full[OFF_W-1:0];
            m3_next.dst_offset = doff_full[OFF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_sx_reg   <= div_reg[Q_W].q_x;
            m1_sy_reg   <= div_reg[Q_W].q_y;
            m1_prod_reg <= sprod_full[NUM_W-1:0];
            m1_dlin_reg <= dlin_next;
            m1_inr_reg  <= side_reg[Q_W].in_range;
            m2_sx_reg   <= m1_sx_reg;
            m2_sy_reg   <= m1_sy_reg;
            m2_slin_reg <= slin_next;
            m2_dlin_reg <= m1_dlin_reg;
            m2_inr_reg  <= m1_inr_reg;
            m3_reg      <= m3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
        end else if (adv) begin
            m1_v_reg <= v_reg[Q_W];
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
        end
    end

    // Output register with one skid entry behind it.
    res_t out_reg, skid_reg;
    logic out_v_reg;
    logic out_free;
    logic pipe_out;

    assign out_free = !out_v_reg || m_tready;
    assign pipe_out = adv && m3_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (out_free) begin
            out_v_reg  <= skid_v_reg || pipe_out;
            skid_v_reg <= 1'b0;
        end else if (pipe_out) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_v_reg ? skid_reg : m3_reg;
        end else if (pipe_out) begin
            skid_reg <= m3_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {3'b000, out_reg.in_range, out_reg.dst_offset, out_reg.src_offset,
                       out_reg.src_y, out_reg.src_x};

    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry holds an item while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(out_v_reg && !m_tready))
        else $error("skid entry filled without a stalled output");

    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && !out_reg.in_range) |->
            (out_reg.src_x == '0 && out_reg.src_y == '0 &&
             out_reg.src_offset == '0 && out_reg.dst_offset == '0))
        else $error("out-of-range result carries nonzero fields");

endmodule
